// ===== rtl/rfpc_pkg.sv =====
// Shared types and constants of the ring FIFO with peek and commit.
// No dependencies; imported by the top level and the checker.
`default_nettype none

package rfpc_pkg;

  localparam int SLOT_COUNT_DEF = 256;
  localparam int WORD_WIDTH_DEF = 32;

  localparam int DATA_W     = 32;
  localparam int CMD_W      = 3;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 8;
  localparam int CFG_W      = 9;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic [CFG_W-1:0] USED_LENGTH_RST = 9'd256;

  // Register index, taken from paddr[2]
  localparam logic REG_USED_LENGTH = 1'b0;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQUEUE = 3'd0,
    CMD_DEQUEUE = 3'd1,
    CMD_PEEK    = 3'd2,
    CMD_COMMIT  = 3'd3,
    CMD_REWIND  = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_OVERFLOW = 2'd1,
    STAT_EMPTY    = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    S_IDLE,
    S_FINISH
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/ring_fifo_with_peek_commit_top.sv =====
// Ring FIFO with committed and peek read pointers over a programmable length.
// An item is accepted in idle; the finish state waits for both remainder units and
// a free output register, then registers the result. The bit-serial modulo pass runs
// only when a pointer lies at or beyond the length (after the length shrank). A new
// item is taken only after the last one finishes: in_stall is high until then.
// Reset: pointers clear, used_length returns to 256, slots undefined until written.
`default_nettype none

module ring_fifo_with_peek_commit_top #(
  parameter int SLOT_COUNT = rfpc_pkg::SLOT_COUNT_DEF,
  parameter int WORD_WIDTH = rfpc_pkg::WORD_WIDTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // APB-style configuration port
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [rfpc_pkg::APB_ADDR_W-1:0]      paddr,
  input  wire logic [rfpc_pkg::APB_DATA_W-1:0]      pwdata,
  output logic      [rfpc_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                      pready,
  // command channel
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [rfpc_pkg::CMD_W-1:0]           command,
  input  wire logic [rfpc_pkg::DATA_W-1:0]          write_data,
  // result channel
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic      [rfpc_pkg::STATUS_W-1:0]        status,
  output logic      [rfpc_pkg::DATA_W-1:0]          read_data,
  output logic                                      is_empty,
  output logic                                      is_full,
  output logic      [rfpc_pkg::COUNT_W-1:0]         item_count
);

  import rfpc_pkg::*;

  localparam int PTR_W = $clog2(SLOT_COUNT);
  localparam int LEN_W = PTR_W + 1;
  localparam int CMP_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;
  localparam int SUM_W = (LEN_W > COUNT_W) ? LEN_W : COUNT_W;

  // Next slot after p, wrapping at the effective length
  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                               input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] n;
    n = {1'b0, p} + 1'b1;
    return (n >= len) ? '0 : n[PTR_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] used_length;
  logic [CMP_W-1:0] used_ext;
  logic [LEN_W-1:0] eff_len;
  logic             cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_USED_LENGTH);
  assign prdata    = (paddr[2] == REG_USED_LENGTH) ? APB_DATA_W'(used_length) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      used_length <= USED_LENGTH_RST;
    end else if (cfg_write) begin
      used_length <= pwdata[CFG_W-1:0];
    end
  end

  // Clamp the length into 1..SLOT_COUNT
  assign used_ext = CMP_W'(used_length);
  always_comb begin
    if (used_ext == '0) begin
      eff_len = LEN_W'(1);
    end else if (used_ext > CMP_W'(SLOT_COUNT)) begin
      eff_len = LEN_W'(SLOT_COUNT);
    end else begin
      eff_len = LEN_W'(used_ext);
    end
  end

  // ---------------------------------------------------------------------------
  // Pointers and command decode
  // ---------------------------------------------------------------------------
  state_t           state, state_next;
  logic [PTR_W-1:0] write_pointer, write_pointer_next;
  logic [PTR_W-1:0] committed_pointer, committed_pointer_next;
  logic [PTR_W-1:0] peek_pointer, peek_pointer_next;
  logic             accept;
  logic             mem_en, mem_we;
  logic [PTR_W-1:0] mem_addr;
  logic [WORD_WIDTH-1:0] mem_q;
  logic [STATUS_W-1:0]   stat_q, stat_next;
  logic             rd_ok, rd_ok_next;
  logic             busy_w, busy_c;
  logic [PTR_W-1:0] rem_w, rem_c;
  logic             done;
  logic [SUM_W-1:0] count_full;
  logic [PTR_W-1:0] write_adv, peek_adv;

  assign accept    = in_valid && !in_stall;
  assign write_adv = advance(write_pointer, eff_len);
  assign peek_adv  = advance(peek_pointer, eff_len);

  always_comb begin
    write_pointer_next     = write_pointer;
    committed_pointer_next = committed_pointer;
    peek_pointer_next      = peek_pointer;
    stat_next              = STAT_OK;
    rd_ok_next             = 1'b0;
    mem_en                 = 1'b0;
    mem_we                 = 1'b0;
    mem_addr               = peek_pointer;
    if (accept) begin
      case (command)
        CMD_ENQUEUE: begin
          if (write_adv == committed_pointer) begin
            stat_next = STAT_OVERFLOW;
          end else begin
            mem_en             = 1'b1;
            mem_we             = 1'b1;
            mem_addr           = write_pointer;
            write_pointer_next = write_adv;
          end
        end
        CMD_DEQUEUE, CMD_PEEK: begin
          if (peek_pointer == write_pointer) begin
            stat_next = STAT_EMPTY;
          end else begin
            // read at the peek slot; data arrives next cycle
            mem_en            = 1'b1;
            rd_ok_next        = 1'b1;
            peek_pointer_next = peek_adv;
            if (command == CMD_DEQUEUE) begin
              committed_pointer_next = peek_adv;
            end
          end
        end
        CMD_COMMIT: committed_pointer_next = peek_pointer;
        CMD_REWIND: peek_pointer_next      = committed_pointer;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer     <= '0;
      committed_pointer <= '0;
      peek_pointer      <= '0;
    end else begin
      write_pointer     <= write_pointer_next;
      committed_pointer <= committed_pointer_next;
      peek_pointer      <= peek_pointer_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stat_q <= stat_next;
      rd_ok  <= rd_ok_next;
    end
  end

  // Commands run one at a time, so a write and a later read of the same slot
  // never fall in the same cycle: no forwarding path is needed.
  rfpc_slot_mem #(
    .DEPTH (SLOT_COUNT),
    .WIDTH (WORD_WIDTH)
  ) u_mem (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (WORD_WIDTH'(write_data)),
    .rdata (mem_q)
  );

  // ---------------------------------------------------------------------------
  // Item count: reduce both pointers modulo the length
  // ---------------------------------------------------------------------------
  rfpc_rem #(.PTR_W(PTR_W)) u_rem_w (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .dividend  (write_pointer_next),
    .divisor   (eff_len),
    .busy      (busy_w),
    .remainder (rem_w)
  );

  rfpc_rem #(.PTR_W(PTR_W)) u_rem_c (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .dividend  (committed_pointer_next),
    .divisor   (eff_len),
    .busy      (busy_c),
    .remainder (rem_c)
  );

  always_comb begin
    if (rem_w >= rem_c) begin
      count_full = SUM_W'(rem_w) - SUM_W'(rem_c);
    end else begin
      count_full = SUM_W'(rem_w) + SUM_W'(eff_len) - SUM_W'(rem_c);
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: accept in idle, finish once the count is ready and the
  // output register is free
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    done       = 1'b0;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        done = !busy_w && !busy_c && (!out_valid || !out_stall);
        if (done) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Pointers hold between accept and finish, so flags come from them directly
  always_ff @(posedge clk) begin
    if (done) begin
      status     <= stat_q;
      read_data  <= rd_ok ? DATA_W'(mem_q) : '0;
      is_empty   <= (write_pointer == committed_pointer);
      is_full    <= (write_adv == committed_pointer);
      item_count <= count_full[COUNT_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rfpc_slot_mem.sv =====
// Slot storage of the ring FIFO: single-port synchronous RAM with a registered read.
// Depends on nothing; instantiated by the top level.
`default_nettype none

module rfpc_slot_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read data holds until the next read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rfpc_rem.sv =====
// Restoring remainder unit: pointer modulo length, one bit per cycle.
// Finishes at once when the pointer is already below the length.
`default_nettype none

module rfpc_rem #(
  parameter int PTR_W = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [PTR_W-1:0] dividend,
  input  wire logic [PTR_W:0]   divisor,
  output logic                  busy,
  output logic      [PTR_W-1:0] remainder
);

  localparam int IDX_W = (PTR_W > 1) ? $clog2(PTR_W) : 1;

  logic [PTR_W-1:0] rem;
  logic [PTR_W-1:0] shift;
  logic [IDX_W-1:0] idx;
  logic [PTR_W:0]   trial;

  assign trial     = {rem, shift[PTR_W-1]};
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= ({1'b0, dividend} >= divisor);
    end else if (busy && (idx == '0)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      if ({1'b0, dividend} < divisor) begin
        rem <= dividend;
      end else begin
        rem <= '0;
      end
      shift <= dividend;
      idx   <= IDX_W'(PTR_W - 1);
    end else if (busy) begin
      // subtract the length wherever the partial remainder reaches it
      rem   <= (trial >= divisor) ? PTR_W'(trial - divisor) : trial[PTR_W-1:0];
      shift <= shift << 1;
      idx   <= idx - 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rfpc_checker.sv =====
// Port-level checks of the ring FIFO with peek and commit, bound to the top.
// Depends on rfpc_pkg.
`default_nettype none

module rfpc_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             out_valid,
  input wire logic                             out_stall,
  input wire logic [rfpc_pkg::STATUS_W-1:0]    status,
  input wire logic [rfpc_pkg::DATA_W-1:0]      read_data,
  input wire logic                             is_empty,
  input wire logic                             is_full,
  input wire logic [rfpc_pkg::COUNT_W-1:0]     item_count
);

  import rfpc_pkg::*;

  // An overflow leaves the pointers alone, so the FIFO must read full
  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STAT_OVERFLOW) |-> is_full)
    else $error("overflow reported while not full");

  // A refused read returns zero data
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STAT_EMPTY) |-> (read_data == '0))
    else $error("empty result carries data");

  // Equal pointers give a zero count
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_empty |-> (item_count == '0))
    else $error("empty FIFO with nonzero count");

  // Held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(status))
    else $error("stalled result changed");

endmodule

bind ring_fifo_with_peek_commit_top rfpc_checker u_rfpc_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .status     (status),
  .read_data  (read_data),
  .is_empty   (is_empty),
  .is_full    (is_full),
  .item_count (item_count)
);

`default_nettype wire

// ===== sim/ring_fifo_with_peek_commit_top_tb.sv =====
// Self-checking testbench for ring_fifo_with_peek_commit_top.
// Depends on rfpc_pkg (command/status codes, widths) and the RTL top only;
// results are checked against an in-bench model of the three-pointer ring.
`timescale 1ns / 100ps

module ring_fifo_with_peek_commit_top_tb;
  import rfpc_pkg::*;

  // Command codes above CMD_REWIND do nothing; the block must still answer them.
  localparam logic [CMD_W-1:0] CMD_NOP_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_NOP_HI = 3'd7;

  localparam int MAX_IDLE = 18;
  // Covers the result path plus the bit-serial modulo pass, with margin.
  localparam int SETTLE_CYCLES = 16;
  localparam int PRINT_LIMIT = 100;

  typedef struct packed {
    status_t              status;
    logic [DATA_W-1:0]    rdata;
    logic                 empty;
    logic                 full;
    logic [COUNT_W-1:0]   count;
  } fifo_result_t;

  localparam fifo_result_t NO_RESULT = '0;

  // One row of the directed plan: either a length write or a command item.
  // Rows with typed set carry a hand-written expected result.
  typedef struct {
    bit                 is_cfg;
    logic [CFG_W-1:0]   len;
    logic [CMD_W-1:0]   cmd;
    logic [DATA_W-1:0]  data;
    bit                 typed;
    fifo_result_t       exp;
  } plan_row_t;

  // One random phase: length setting, number of items, enqueue share in percent.
  typedef struct {
    logic [CFG_W-1:0] len;
    int               items;
    int               enq_pct;
  } phase_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid;
  logic                  in_stall;
  logic [CMD_W-1:0]      command;
  logic [DATA_W-1:0]     write_data;
  logic                  out_valid;
  logic                  out_stall;
  logic [STATUS_W-1:0]   status;
  logic [DATA_W-1:0]     read_data;
  logic                  is_empty;
  logic                  is_full;
  logic [COUNT_W-1:0]    item_count;

  // Ring model: slot contents, which slots hold data, the three pointers, the length.
  logic [DATA_W-1:0] slot_mem [SLOT_COUNT_DEF];
  bit                slot_written [SLOT_COUNT_DEF];
  int unsigned       wr_ptr;
  int unsigned       cmt_ptr;
  int unsigned       pk_ptr;
  logic [CFG_W-1:0]  length_reg;

  fifo_result_t pending_results [$];

  int  error_count = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  overflow_seen = 0;
  int  empty_refusals = 0;
  int  full_seen = 0;
  int  length_writes = 0;
  bit  tx_gappy = 1'b0;
  bit  rx_gappy = 1'b1;

  // Directed plan. Opens on the reset state with hand-typed results, then shrinks
  // the length to the pointers' value, drops to one slot and to the out-of-range codes.
  plan_row_t directed_plan [30] = '{
    // empty refusals right after reset
    '{1'b0, 9'd0, CMD_PEEK,    32'h0000_0000, 1'b1, '{STAT_EMPTY, 32'h0, 1'b1, 1'b0, 8'd0}},
    '{1'b0, 9'd0, CMD_DEQUEUE, 32'hFFFF_FFFF, 1'b1, '{STAT_EMPTY, 32'h0, 1'b1, 1'b0, 8'd0}},
    // load three items, data extremes first
    '{1'b0, 9'd0, CMD_ENQUEUE, 32'h0000_0000, 1'b1, '{STAT_OK, 32'h0, 1'b0, 1'b0, 8'd1}},
    '{1'b0, 9'd0, CMD_ENQUEUE, 32'hFFFF_FFFF, 1'b1, '{STAT_OK, 32'h0, 1'b0, 1'b0, 8'd2}},
    '{1'b0, 9'd0, CMD_ENQUEUE, 32'h5A5A_A5A5, 1'b1, '{STAT_OK, 32'h0, 1'b0, 1'b0, 8'd3}},
    // peek twice, rewind, peek again: the count follows the committed pointer only
    '{1'b0, 9'd0, CMD_PEEK,    32'h0000_0000, 1'b1, '{STAT_OK, 32'h0, 1'b0, 1'b0, 8'd3}},
    '{1'b0, 9'd0, CMD_PEEK,    32'h0000_0000, 1'b1,
      '{STAT_OK, 32'hFFFF_FFFF, 1'b0, 1'b0, 8'd3}},
    '{1'b0, 9'd0, CMD_REWIND,  32'h0000_0000, 1'b1, '{STAT_OK, 32'h0, 1'b0, 1'b0, 8'd3}},
    '{1'b0, 9'd0, CMD_PEEK,    32'h0000_0000, 1'b1, '{STAT_OK, 32'h0, 1'b0, 1'b0, 8'd3}},
    '{1'b0, 9'd0, CMD_COMMIT,  32'h0000_0000, 1'b1, '{STAT_OK, 32'h0, 1'b0, 1'b0, 8'd2}},
    '{1'b0, 9'd0, CMD_DEQUEUE, 32'h0000_0000, 1'b1,
      '{STAT_OK, 32'hFFFF_FFFF, 1'b0, 1'b0, 8'd1}},
    // unknown codes leave everything alone
    '{1'b0, 9'd0, CMD_NOP_LO,  32'hFFFF_FFFF, 1'b1, '{STAT_OK, 32'h0, 1'b0, 1'b0, 8'd1}},
    '{1'b0, 9'd0, CMD_NOP_HI,  32'h0000_0000, 1'b1, '{STAT_OK, 32'h0, 1'b0, 1'b0, 8'd1}},
    '{1'b0, 9'd0, CMD_DEQUEUE, 32'h0000_0000, 1'b1,
      '{STAT_OK, 32'h5A5A_A5A5, 1'b1, 1'b0, 8'd0}},
    '{1'b0, 9'd0, CMD_COMMIT,  32'h0000_0000, 1'b1, '{STAT_OK, 32'h0, 1'b1, 1'b0, 8'd0}},
    '{1'b0, 9'd0, CMD_REWIND,  32'h0000_0000, 1'b1, '{STAT_OK, 32'h0, 1'b1, 1'b0, 8'd0}},
    // shrink to three slots while all pointers sit at three
    '{1'b1, 9'd3, CMD_ENQUEUE, 32'h0000_0000, 1'b0, NO_RESULT},
    '{1'b0, 9'd0, CMD_ENQUEUE, 32'h8000_0001, 1'b0, NO_RESULT},
    '{1'b0, 9'd0, CMD_ENQUEUE, 32'h7FFF_FFFE, 1'b0, NO_RESULT},
    '{1'b0, 9'd0, CMD_ENQUEUE, 32'h0F0F_0F0F, 1'b0, NO_RESULT},
    '{1'b0, 9'd0, CMD_DEQUEUE, 32'h0000_0000, 1'b0, NO_RESULT},
    '{1'b0, 9'd0, CMD_ENQUEUE, 32'hF0F0_F0F0, 1'b0, NO_RESULT},
    // single slot, then a zero length that must act as one
    '{1'b1, 9'd1, CMD_ENQUEUE, 32'h0000_0000, 1'b0, NO_RESULT},
    '{1'b0, 9'd0, CMD_ENQUEUE, 32'h1234_5678, 1'b0, NO_RESULT},
    '{1'b0, 9'd0, CMD_PEEK,    32'h0000_0000, 1'b0, NO_RESULT},
    '{1'b1, 9'd0, CMD_ENQUEUE, 32'h0000_0000, 1'b0, NO_RESULT},
    '{1'b0, 9'd0, CMD_ENQUEUE, 32'hCAFE_0001, 1'b0, NO_RESULT},
    '{1'b0, 9'd0, CMD_COMMIT,  32'h0000_0000, 1'b0, NO_RESULT},
    // largest code, which must clamp to the full slot count
    '{1'b1, 9'd511, CMD_ENQUEUE, 32'h0000_0000, 1'b0, NO_RESULT},
    '{1'b0, 9'd0, CMD_ENQUEUE, 32'hFFFF_0000, 1'b0, NO_RESULT}
  };

  // Random phases. Small rings wrap and overflow often; the full-size pair fills
  // the ring to capacity and then drains it.
  phase_t phase_plan [12] = '{
    '{9'd2,   120, 45},
    '{9'd256, 300, 85},
    '{9'd256, 200, 20},
    '{9'd1,    40, 40},
    '{9'd0,    40, 40},
    '{9'd511, 100, 50},
    '{9'd7,   150, 45},
    '{9'd17,  150, 50},
    '{9'd300,  80, 55},
    '{9'd4,   100, 40},
    '{9'd33,  100, 55},
    '{9'd128,  80, 50}
  };

  ring_fifo_with_peek_commit_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .write_data (write_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .read_data  (read_data),
    .is_empty   (is_empty),
    .is_full    (is_full),
    .item_count (item_count)
  );

  always #4 clk = ~clk;

  // Advance a pointer by one, wrapping to zero at the length. A pointer left
  // beyond a shrunken length also lands on zero.
  function automatic int unsigned next_slot(int unsigned ptr, int unsigned len);
    return (ptr + 1 >= len) ? 0 : ptr + 1;
  endfunction

  // Apply one command to the ring model and return the result it must produce.
  function automatic fifo_result_t ring_step(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] data);
    int unsigned  len;
    int unsigned  nxt;
    fifo_result_t r;
    len = (length_reg == 0) ? 1 : ((length_reg > SLOT_COUNT_DEF) ? SLOT_COUNT_DEF : length_reg);
    r = NO_RESULT;
    r.status = STAT_OK;
    case (cmd)
      CMD_ENQUEUE: begin
        nxt = next_slot(wr_ptr, len);
        if (nxt == cmt_ptr) begin
          r.status = STAT_OVERFLOW;
        end else begin
          slot_mem[wr_ptr] = data;
          slot_written[wr_ptr] = 1'b1;
          wr_ptr = nxt;
        end
      end
      CMD_DEQUEUE, CMD_PEEK: begin
        if (pk_ptr == wr_ptr) begin
          r.status = STAT_EMPTY;
        end else begin
          r.rdata = slot_mem[pk_ptr];
          pk_ptr = next_slot(pk_ptr, len);
          if (cmd == CMD_DEQUEUE) cmt_ptr = pk_ptr;
        end
      end
      CMD_COMMIT: cmt_ptr = pk_ptr;
      CMD_REWIND: pk_ptr = cmt_ptr;
      default: ;
    endcase
    r.empty = (wr_ptr == cmt_ptr);
    r.full  = (next_slot(wr_ptr, len) == cmt_ptr);
    // count reduces both pointers modulo the length first
    r.count = COUNT_W'(((wr_ptr % len) + len - (cmt_ptr % len)) % len);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    error_count++;
    if (error_count <= PRINT_LIMIT)
      $display("%0t ns: %s mismatch at result %0d: got %0h, expected %0h",
               $time, what, results_seen, got, want);
  endtask

  // Send one item: idle for a drawn gap, present it, hold it through stalls,
  // and log the expected result once it is taken. Entered and left at a falling edge.
  task automatic send_item(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] data,
                           bit typed, fifo_result_t typed_exp);
    int           gap;
    fifo_result_t predicted;
    gap = tx_gappy ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    write_data <= data;
    do @(posedge clk); while (in_stall);
    predicted = ring_step(cmd, data);
    pending_results.push_back(typed ? typed_exp : predicted);
    items_sent++;
    if ($urandom_range(0, 63) == 0) tx_gappy = !tx_gappy;
    @(negedge clk);
  endtask

  // Wait for the ring to go quiet, then write used_length and read it back.
  // Entered and left at a falling edge with in_valid already low.
  task automatic set_length(logic [CFG_W-1:0] len);
    while (pending_results.size() != 0) @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_USED_LENGTH, 2'b00};
    pwdata  <= APB_DATA_W'(len);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    length_reg = len;
    length_writes++;
    // go straight from the write access into the read setup
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== APB_DATA_W'(len)) report_mismatch("used_length readback", prdata, len);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Result side: stall for a drawn number of cycles before each result,
  // switching between gappy and back-to-back stretches.
  initial begin : result_sink
    int hold;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      hold = rx_gappy ? $urandom_range(0, MAX_IDLE) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      if ($urandom_range(0, 63) == 0) rx_gappy = !rx_gappy;
      @(negedge clk);
    end
  end

  // Check every accepted result against the oldest expectation, field by field.
  always @(posedge clk) begin : result_check
    fifo_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, status", status, '0);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status)        report_mismatch("status", status, want.status);
        if (read_data !== want.rdata)      report_mismatch("read_data", read_data, want.rdata);
        if (is_empty !== want.empty)       report_mismatch("is_empty", is_empty, want.empty);
        if (is_full !== want.full)         report_mismatch("is_full", is_full, want.full);
        if (item_count !== want.count)     report_mismatch("item_count", item_count, want.count);
        if (want.status == STAT_OVERFLOW)  overflow_seen++;
        if (want.status == STAT_EMPTY)     empty_refusals++;
        if (want.full)                     full_seen++;
      end
      results_seen++;
    end
  end

  // Hard stop well beyond the slowest legal run.
  initial begin : watchdog
    #4_000_000;
    $display("timeout with %0d results still outstanding", pending_results.size());
    $display("ring_fifo_with_peek_commit_top_tb NOT OK");
    $finish;
  end

  initial begin : stimulus
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] data;
    int                pick;

    rst        = 1'b1;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    in_valid   = 1'b0;
    command    = CMD_ENQUEUE;
    write_data = '0;

    wr_ptr     = 0;
    cmt_ptr    = 0;
    pk_ptr     = 0;
    length_reg = USED_LENGTH_RST;
    foreach (slot_written[i]) slot_written[i] = 1'b0;

    // Hold reset, then release it at a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the directed plan.
    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_cfg) begin
        in_valid <= 1'b0;
        set_length(directed_plan[i].len);
      end else begin
        send_item(directed_plan[i].cmd, directed_plan[i].data,
                  directed_plan[i].typed, directed_plan[i].exp);
      end
    end

    // Random phases, one length setting each.
    foreach (phase_plan[p]) begin
      in_valid <= 1'b0;
      set_length(phase_plan[p].len);
      for (int n = 0; n < phase_plan[p].items; n++) begin
        if ($urandom_range(0, 99) < phase_plan[p].enq_pct) begin
          cmd = CMD_ENQUEUE;
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 35)      cmd = CMD_DEQUEUE;
          else if (pick < 65) cmd = CMD_PEEK;
          else if (pick < 78) cmd = CMD_COMMIT;
          else if (pick < 91) cmd = CMD_REWIND;
          else                cmd = CMD_NOP_LO + CMD_W'($urandom_range(0, CMD_NOP_HI - CMD_NOP_LO));
        end
        // Never read a slot that holds no data yet; enqueue instead.
        if ((cmd == CMD_DEQUEUE || cmd == CMD_PEEK) && pk_ptr != wr_ptr &&
            !slot_written[pk_ptr])
          cmd = CMD_ENQUEUE;
        case ($urandom_range(0, 7))
          0:       data = '0;
          1:       data = '1;
          default: data = $urandom;
        endcase
        send_item(cmd, data, 1'b0, NO_RESULT);
      end
    end

    // Drain: wait for every expected result, then watch for strays.
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d commands over %0d used_length writes; %0d results checked.",
             items_sent, length_writes, results_seen);
    $display("Saw %0d overflows, %0d empty refusals, %0d results with the full flag set.",
             overflow_seen, empty_refusals, full_seen);
    if (error_count == 0) begin
      $display("ring_fifo_with_peek_commit_top_tb OK");
    end else begin
      $display("%0d mismatches", error_count);
      $display("ring_fifo_with_peek_commit_top_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rfpc_pkg.sv
rtl/rfpc_slot_mem.sv
rtl/rfpc_rem.sv
rtl/ring_fifo_with_peek_commit_top.sv
rtl/rfpc_checker.sv
sim/ring_fifo_with_peek_commit_top_tb.sv
